// ===== hdl/suffix_array_lcp_builder_macros.svh =====
// Assertion macros used by the checker in salcp_chk.sv.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH

// ante holds at one edge, cons must hold at the next edge
`define SALCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// expr must never hold outside reset
`define SALCP_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== hdl/salcp_pkg.sv =====
// Shared types, widths and codes for the suffix array / LCP builder.
// No dependencies; used by every module of the block.
package salcp_pkg;

	localparam int MAX_LEN_DEF = 64;
	localparam int BYTE_W      = 8;
	localparam int POS_W       = 6;
	localparam int RANK_W      = 8;
	localparam int KEY_W       = RANK_W + 1;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [POS_W-1:0] suffix_start;
		logic [POS_W-1:0] common_prefix;
		logic             last_entry;
		logic             truncated;
	} out_word_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_IRD,
		ST_ILAT,
		ST_JRD,
		ST_JCMP,
		ST_IWR,
		ST_RNEXT,
		ST_PRD,
		ST_PWR,
		ST_KRD,
		ST_KRANK,
		ST_KSA,
		ST_KTRD,
		ST_KTCMP,
		ST_KWR,
		ST_ERD,
		ST_ELD,
		ST_EWAIT
	} state_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_START,
		OP_IRD,
		OP_ILAT,
		OP_JRD,
		OP_JCMP,
		OP_IWR,
		OP_RNEXT,
		OP_PRD,
		OP_PWR,
		OP_KRD,
		OP_KRANK,
		OP_KSKIP,
		OP_KSA,
		OP_KTRD,
		OP_KTCMP,
		OP_KWR,
		OP_ERD,
		OP_ELD,
		OP_ENEXT,
		OP_FINISH
	} op_t;

	typedef struct packed {
		logic i_last;
		logic j_last;
		logic k2_lt_n;
		logic rank_zero;
		logic bounds_ok;
		logic text_eq;
		logic out_taken;
	} status_t;

endpackage

// ===== hdl/salcp_dp.sv =====
// Datapath: text, rank, suffix and LCP memories, loop counters, output register.
// Depends on salcp_pkg; driven one operation per cycle by salcp_ctrl.
module salcp_dp import salcp_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  op_t       op,
	input  in_word_t  in_word,
	input  logic      out_ready,
	output logic      out_valid,
	output out_word_t out_word,
	output status_t   status
);

	localparam int IW    = $clog2(MAX_LEN);
	localparam int LW    = $clog2(MAX_LEN + 1);
	localparam int KW    = LW + 1;
	localparam int DEPTH = 1 << IW;

	logic [BYTE_W-1:0] text_mem [DEPTH];
	logic [RANK_W-1:0] rank_mem [2*DEPTH];
	logic [IW-1:0]     sa_mem   [DEPTH];
	logic [POS_W-1:0]  lcp_mem  [DEPTH];

	logic [LW-1:0]     len_q;
	logic              ovf_q;
	logic [KW-1:0]     k_q;
	logic              bank_q;
	logic [IW-1:0]     i_q, j_q, acc_q, r_q, jpos_q;
	logic [LW-1:0]     h_q;
	logic [RANK_W-1:0] pa_q;
	logic [KEY_W-1:0]  pb_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic [RANK_W-1:0] rank_rd0_q, rank_rd1_q;
	logic [BYTE_W-1:0] text_rd0_q, text_rd1_q;
	logic [IW-1:0]     sa_rd_q;
	logic [POS_W-1:0]  lcp_rd_q;

	logic [IW-1:0]     idx0, idx1, sa_ra, ta0, ta1;
	logic [KW-1:0]     sum0, sum_ih, sum_jh;
	logic              key_in;
	logic [KEY_W-1:0]  key_rd;
	logic              pair_less, has_room, i_last;

	assign has_room = len_q < LW'(MAX_LEN);
	assign i_last   = (LW'(i_q) + LW'(1)) == len_q;

	// second rank of the pair is read at idx0 + k
	assign idx0   = (op == OP_JRD) ? j_q : i_q;
	assign sum0   = KW'(idx0) + k_q;
	assign idx1   = sum0[IW-1:0];
	assign key_in = (op == OP_JCMP) ? ((KW'(j_q) + k_q) < KW'(len_q))
	                                : ((KW'(i_q) + k_q) < KW'(len_q));
	assign key_rd = key_in ? (KEY_W'(rank_rd1_q) + KEY_W'(1)) : '0;
	assign pair_less = (rank_rd0_q < pa_q) || ((rank_rd0_q == pa_q) && (key_rd < pb_q));

	assign sum_ih = KW'(i_q) + KW'(h_q);
	assign sum_jh = KW'(jpos_q) + KW'(h_q);
	assign ta0    = sum_ih[IW-1:0];
	assign ta1    = sum_jh[IW-1:0];
	assign sa_ra  = (op == OP_KRANK) ? (rank_rd0_q[IW-1:0] - IW'(1)) : i_q;

	assign status.i_last    = i_last;
	assign status.j_last    = (LW'(j_q) + LW'(1)) == len_q;
	assign status.k2_lt_n   = (k_q << 1) < KW'(len_q);
	assign status.rank_zero = rank_rd0_q == '0;
	assign status.bounds_ok = (sum_ih < KW'(len_q)) && (sum_jh < KW'(len_q));
	assign status.text_eq   = text_rd0_q == text_rd1_q;
	assign status.out_taken = out_valid_q && out_ready;

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// memories
	always_ff @(posedge clk) begin
		if ((op == OP_LOAD || op == OP_START) && has_room) begin
			text_mem[len_q[IW-1:0]]         <= in_word.text_byte;
			rank_mem[{1'b0, len_q[IW-1:0]}] <= in_word.text_byte;
		end
		if (op == OP_IWR) begin
			rank_mem[{~bank_q, i_q}] <= RANK_W'(acc_q);
		end
		if (op == OP_PWR) begin
			sa_mem[rank_rd0_q[IW-1:0]] <= i_q;
		end
		if (op == OP_KWR) begin
			lcp_mem[r_q] <= POS_W'(h_q);
		end
		rank_rd0_q <= rank_mem[{bank_q, idx0}];
		rank_rd1_q <= rank_mem[{bank_q, idx1}];
		text_rd0_q <= text_mem[ta0];
		text_rd1_q <= text_mem[ta1];
		sa_rd_q    <= sa_mem[sa_ra];
		lcp_rd_q   <= lcp_mem[i_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (op == OP_ILAT) begin
			pa_q <= rank_rd0_q;
			pb_q <= key_rd;
		end
		if (op == OP_KRANK) begin
			r_q <= rank_rd0_q[IW-1:0];
		end
		if (op == OP_KSA) begin
			jpos_q <= sa_rd_q;
		end
		if (op == OP_ELD) begin
			out_word_q.suffix_start  <= POS_W'(sa_rd_q);
			out_word_q.common_prefix <= (i_q == '0) ? '0 : lcp_rd_q;
			out_word_q.last_entry    <= i_last;
			out_word_q.truncated     <= ovf_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			bank_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			acc_q       <= '0;
			h_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (status.out_taken) begin
				out_valid_q <= 1'b0;
			end
			unique case (op)
				OP_LOAD, OP_START: begin
					if (has_room) begin
						len_q <= len_q + LW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					if (op == OP_START) begin
						k_q    <= KW'(1);
						bank_q <= 1'b0;
						i_q    <= '0;
					end
				end
				OP_ILAT: begin
					j_q   <= '0;
					acc_q <= '0;
				end
				OP_JCMP: begin
					acc_q <= acc_q + IW'(pair_less);
					j_q   <= j_q + IW'(1);
				end
				OP_IWR, OP_PWR, OP_KSKIP, OP_ENEXT: begin
					i_q <= i_last ? '0 : i_q + IW'(1);
				end
				OP_RNEXT: begin
					bank_q <= ~bank_q;
					k_q    <= k_q << 1;
					i_q    <= '0;
					h_q    <= '0;
				end
				OP_KTCMP: begin
					if (status.text_eq) begin
						h_q <= h_q + LW'(1);
					end
				end
				OP_KWR: begin
					if (h_q != '0) begin
						h_q <= h_q - LW'(1);
					end
					i_q <= i_last ? '0 : i_q + IW'(1);
				end
				OP_ELD: begin
					out_valid_q <= 1'b1;
				end
				OP_FINISH: begin
					len_q <= '0;
					ovf_q <= 1'b0;
					i_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/salcp_ctrl.sv =====
// Controller: sequences load, doubling rounds, placement, LCP scan and emission.
// Depends on salcp_pkg; issues one op_t per cycle to salcp_dp.
module salcp_ctrl import salcp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    end_of_text,
	input  status_t status,
	output logic    in_ready,
	output op_t     op
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		op        = OP_IDLE;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = end_of_text ? OP_START : OP_LOAD;
					if (end_of_text) begin
						state_nxt = ST_IRD;
					end
				end
			end
			ST_IRD: begin
				op        = OP_IRD;
				state_nxt = ST_ILAT;
			end
			ST_ILAT: begin
				op        = OP_ILAT;
				state_nxt = ST_JRD;
			end
			ST_JRD: begin
				op        = OP_JRD;
				state_nxt = ST_JCMP;
			end
			ST_JCMP: begin
				op        = OP_JCMP;
				state_nxt = status.j_last ? ST_IWR : ST_JRD;
			end
			ST_IWR: begin
				op        = OP_IWR;
				state_nxt = status.i_last ? ST_RNEXT : ST_IRD;
			end
			ST_RNEXT: begin
				op        = OP_RNEXT;
				state_nxt = status.k2_lt_n ? ST_IRD : ST_PRD;
			end
			ST_PRD: begin
				op        = OP_PRD;
				state_nxt = ST_PWR;
			end
			ST_PWR: begin
				op        = OP_PWR;
				state_nxt = status.i_last ? ST_KRD : ST_PRD;
			end
			ST_KRD: begin
				op        = OP_KRD;
				state_nxt = ST_KRANK;
			end
			ST_KRANK: begin
				// the suffix ranked first has no predecessor: skip it
				if (status.rank_zero) begin
					op        = OP_KSKIP;
					state_nxt = status.i_last ? ST_ERD : ST_KRD;
				end else begin
					op        = OP_KRANK;
					state_nxt = ST_KSA;
				end
			end
			ST_KSA: begin
				op        = OP_KSA;
				state_nxt = ST_KTRD;
			end
			ST_KTRD: begin
				op        = OP_KTRD;
				state_nxt = status.bounds_ok ? ST_KTCMP : ST_KWR;
			end
			ST_KTCMP: begin
				op        = OP_KTCMP;
				state_nxt = status.text_eq ? ST_KTRD : ST_KWR;
			end
			ST_KWR: begin
				op        = OP_KWR;
				state_nxt = status.i_last ? ST_ERD : ST_KRD;
			end
			ST_ERD: begin
				op        = OP_ERD;
				state_nxt = ST_ELD;
			end
			ST_ELD: begin
				op        = OP_ELD;
				state_nxt = ST_EWAIT;
			end
			ST_EWAIT: begin
				if (status.out_taken) begin
					op        = status.i_last ? OP_FINISH : OP_ENEXT;
					state_nxt = status.i_last ? ST_LOAD : ST_ERD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

endmodule

// ===== hdl/suffix_array_lcp_builder.sv =====
// Channel   Dir  Word        Fields
// in        in   in_word_t   text_byte, end_of_text
// out       out  out_word_t  suffix_start, common_prefix, last_entry, truncated
//
// Bytes load one per cycle. After the last byte, with n stored bytes,
// max(1, ceil(log2 n)) prefix-doubling rounds run, each ranking the
// suffixes by counting through the rank memory; then placement fills the
// suffix array, the LCP scan skips the first suffix and compares each other
// one with its predecessor byte by byte, and emission waits on output stalls.
// No byte is taken while a run is sorting or emitting. Reset is async, active low.
// Top level: instantiates salcp_ctrl and salcp_dp; depends on salcp_pkg.
module suffix_array_lcp_builder import salcp_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	op_t     op;
	status_t status;

	salcp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.end_of_text (in_word.end_of_text),
		.status      (status),
		.in_ready    (in_ready),
		.op          (op)
	);

	salcp_dp #(
		.MAX_LEN (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_word   (in_word),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_word  (out_word),
		.status    (status)
	);

endmodule

// ===== hdl/salcp_chk.sv =====
// Port-level checker for suffix_array_lcp_builder, attached by bind.
// Depends on salcp_pkg and suffix_array_lcp_builder_macros.svh.
`include "suffix_array_lcp_builder_macros.svh"

module salcp_chk import salcp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_word,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);

	`SALCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "output word changed while stalled")
	`SALCP_ASSERT_NEVER(a_no_overlap, in_ready && out_valid, "input taken while results pending")
	`SALCP_ASSERT_NEXT(a_run_starts, in_valid && in_ready && in_word.end_of_text, !in_ready, "input still open after last byte")
	`SALCP_ASSERT_NEXT(a_run_ends, out_valid && out_ready && out_word.last_entry, in_ready && !out_valid, "block not back to loading after last result")

endmodule

bind suffix_array_lcp_builder salcp_chk u_salcp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
